// ===== hdl/rsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio serial frame receiver package
// Frame kind codes, frame type bytes and the classifier result type.
// ----------------------------------------------------------------------------
package rsfr_pkg;

    localparam logic [7:0] FILL_BYTE     = 8'hFF;

    localparam logic [7:0] TYPE_PONG     = 8'h03;
    localparam logic [7:0] TYPE_HEADER   = 8'h10;
    localparam logic [7:0] TYPE_DATA     = 8'h12;
    localparam logic [7:0] TYPE_HDR_ACK  = 8'h21;
    localparam logic [7:0] TYPE_DATA_ACK = 8'h23;

    typedef enum logic [2:0] {
        KIND_PONG     = 3'd0,
        KIND_HEADER   = 3'd1,
        KIND_DATA     = 3'd2,
        KIND_HDR_ACK  = 3'd3,
        KIND_DATA_ACK = 3'd4,
        KIND_UNKNOWN  = 3'd5,
        KIND_LEN_ERR  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  send_ack;
        logic  ack_ok;
    } t_class_info;

endpackage

// ===== hdl/rsfr_classify.sv =====
// ----------------------------------------------------------------------------
// Radio serial frame classifier
// Maps the type byte to a frame kind and derives the reply and code flags.
// ----------------------------------------------------------------------------
module rsfr_classify (
    input  logic [7:0]           i_type_byte,
    input  logic [7:0]           i_second_byte,
    input  logic [7:0]           i_third_byte,
    output rsfr_pkg::t_class_info o_info
);
    import rsfr_pkg::*;

    always_comb begin
        o_info = '{kind: KIND_UNKNOWN, send_ack: 1'b0, ack_ok: 1'b0};
        case (i_type_byte)
            TYPE_PONG: begin
                o_info.kind = KIND_PONG;
            end
            TYPE_HEADER: begin
                o_info.kind     = KIND_HEADER;
                o_info.send_ack = 1'b1;
            end
            TYPE_DATA: begin
                o_info.kind     = KIND_DATA;
                o_info.send_ack = 1'b1;
            end
            TYPE_HDR_ACK: begin
                o_info.kind   = KIND_HDR_ACK;
                o_info.ack_ok = (i_second_byte == 8'd0);
            end
            TYPE_DATA_ACK: begin
                o_info.kind   = KIND_DATA_ACK;
                o_info.ack_ok = (i_third_byte == 8'd0);
            end
            default: begin
                o_info.kind = KIND_UNKNOWN;
            end
        endcase
    end

endmodule

// ===== hdl/radio_serial_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Radio serial frame receiver
// Cuts a received byte stream into length-prefixed frames and classifies them.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one received byte per
// transaction on i_rx_byte. Output channel: o_res_valid / i_res_ready carry
// one result per frame byte: the byte, its index, and on the last byte the
// frame kind, reply flag, sequence byte and acknowledgement code flag.
// A fill byte outside a frame is dropped and gives no result. A length byte
// at or above FRAME_LIMIT gives one length-error result.
// A byte is held in the input register and its result is then loaded into
// the output register. Throughput: one byte per cycle while the receiver
// does not stall, set by the single pass of logic between the input
// register and the output register.
// Reset clears both valid flags and the frame state; the block then waits
// for a length byte. When the receiver stalls, the result is held and the
// input register still takes one more byte; further bytes wait until the
// result is taken. Dropped fill bytes drain even while the output stalls.
// ----------------------------------------------------------------------------
module radio_serial_frame_receiver_unit #(
    parameter int FRAME_LIMIT = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [7:0]           o_out_byte,
    output logic [6:0]           o_byte_index,
    output logic                 o_last,
    output rsfr_pkg::t_kind      o_kind,
    output logic                 o_send_ack,
    output logic [7:0]           o_ack_seq,
    output logic                 o_ack_ok
);
    import rsfr_pkg::*;

    localparam logic [8:0] LIMIT = 9'(FRAME_LIMIT);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    logic        r_in_frame;
    logic [7:0]  r_position;
    logic [7:0]  r_frame_length;
    logic [7:0]  r_type_byte;
    logic [7:0]  r_second_byte;
    logic [7:0]  r_third_byte;

    logic        r_res_valid;
    logic [7:0]  r_out_byte;
    logic [6:0]  r_byte_index;
    logic        r_last;
    t_kind       r_kind;
    logic        r_send_ack;
    logic [7:0]  r_ack_seq;
    logic        r_ack_ok;

    logic        n_in_frame;
    logic [7:0]  n_position;
    logic [7:0]  n_frame_length;
    logic [7:0]  n_type_byte;
    logic [7:0]  n_second_byte;
    logic [7:0]  n_third_byte;
    logic [6:0]  n_byte_index;
    logic        n_last;
    t_kind       n_kind;
    logic        n_send_ack;
    logic [7:0]  n_ack_seq;
    logic        n_ack_ok;

    logic        drop;
    logic        out_free;
    logic        advance;
    logic        emit;
    logic        frame_end;
    t_class_info class_info;

    assign drop      = !r_in_frame && (r_in_byte == FILL_BYTE);
    assign out_free  = !r_res_valid || i_res_ready;
    assign advance   = r_in_valid && (drop || out_free);
    assign emit      = advance && !drop;
    assign o_in_ready = !r_in_valid || advance;

    assign frame_end = ({1'b0, r_position} + 9'd1) >= {1'b0, r_frame_length};

    rsfr_classify u_classify (
        .i_type_byte   (n_type_byte),
        .i_second_byte (n_second_byte),
        .i_third_byte  (n_third_byte),
        .o_info        (class_info)
    );

    always_comb begin
        n_frame_length = r_frame_length;
        n_type_byte    = r_type_byte;
        n_second_byte  = r_second_byte;
        n_third_byte   = r_third_byte;
        if (!r_in_frame) begin
            if (({1'b0, r_in_byte} < LIMIT) && (r_in_byte > 8'd1)) begin
                n_frame_length = r_in_byte;
                n_type_byte    = 8'd0;
                n_second_byte  = 8'd0;
                n_third_byte   = 8'd0;
            end
        end else if (r_position == 8'd1) begin
            n_type_byte = r_in_byte;
        end else if (r_position == 8'd2) begin
            n_second_byte = r_in_byte;
        end else if (r_position == 8'd3) begin
            n_third_byte = r_in_byte;
        end
    end

    always_comb begin
        n_in_frame     = r_in_frame;
        n_position     = r_position;
        n_byte_index   = 7'd0;
        n_last         = 1'b0;
        n_kind         = KIND_PONG;
        n_send_ack     = 1'b0;
        n_ack_seq      = 8'd0;
        n_ack_ok       = 1'b0;
        if (!r_in_frame) begin
            if ({1'b0, r_in_byte} >= LIMIT) begin
                n_last = 1'b1;
                n_kind = KIND_LEN_ERR;
            end else if (r_in_byte <= 8'd1) begin
                n_last = 1'b1;
                n_kind = KIND_UNKNOWN;
            end else begin
                n_in_frame     = 1'b1;
                n_position     = 8'd1;
            end
        end else begin
            n_byte_index = r_position[6:0];
            if (frame_end) begin
                n_last     = 1'b1;
                n_kind     = class_info.kind;
                n_send_ack = class_info.send_ack;
                n_ack_seq  = n_second_byte;
                n_ack_ok   = class_info.ack_ok;
                n_in_frame = 1'b0;
                n_position = 8'd0;
            end else begin
                n_position = r_position + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_frame  <= 1'b0;
            r_position  <= 8'd0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (emit) begin
                r_in_frame  <= n_in_frame;
                r_position  <= n_position;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (emit) begin
            r_frame_length <= n_frame_length;
            r_type_byte    <= n_type_byte;
            r_second_byte  <= n_second_byte;
            r_third_byte   <= n_third_byte;
            r_out_byte     <= r_in_byte;
            r_byte_index   <= n_byte_index;
            r_last         <= n_last;
            r_kind         <= n_kind;
            r_send_ack     <= n_send_ack;
            r_ack_seq      <= n_ack_seq;
            r_ack_ok       <= n_ack_ok;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_index = r_byte_index;
    assign o_last       = r_last;
    assign o_kind       = r_kind;
    assign o_send_ack   = r_send_ack;
    assign o_ack_seq    = r_ack_seq;
    assign o_ack_ok     = r_ack_ok;

endmodule

// ===== test/rsfr_frame_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radio serial frame receiver monitor
// Watches the byte and result channels and keeps its own deframer state.
// Each accepted byte bar an out-of-frame fill byte queues its expected result.
// Each accepted result is compared field by field with the oldest queued one.
// A mismatch, or a result with none queued, is reported and counted.
// ----------------------------------------------------------------------------
module rsfr_frame_monitor #(
    parameter int FRAME_LIMIT = 100
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_res_valid,
    input  logic            i_res_ready,
    input  logic [7:0]      i_out_byte,
    input  logic [6:0]      i_byte_index,
    input  logic            i_last,
    input  rsfr_pkg::t_kind i_kind,
    input  logic            i_send_ack,
    input  logic [7:0]      i_ack_seq,
    input  logic            i_ack_ok,
    output int              o_fail_count,
    output int              o_pending
);
    import rsfr_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic [6:0] index;
        logic       last;
        t_kind      kind;
        logic       send_ack;
        logic [7:0] seq;
        logic       ok;
    } t_frame_result;

    logic          in_frame;
    logic [7:0]    next_pos;
    logic [7:0]    frame_len;
    logic [7:0]    type_seen;
    logic [7:0]    seq_seen;
    logic [7:0]    code_seen;
    t_frame_result expected_results[$];
    int            fail_total = 0;
    int            result_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, result_count, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic bit deframe_byte(input logic [7:0] b, output t_frame_result r);
        r.data     = b;
        r.index    = 7'd0;
        r.last     = 1'b0;
        r.kind     = KIND_PONG;
        r.send_ack = 1'b0;
        r.seq      = 8'd0;
        r.ok       = 1'b0;
        if (!in_frame) begin
            if (b == FILL_BYTE)
                return 1'b0;
            if (int'(b) >= FRAME_LIMIT) begin
                r.last = 1'b1;
                r.kind = KIND_LEN_ERR;
                return 1'b1;
            end
            if (b <= 8'd1) begin
                r.last = 1'b1;
                r.kind = KIND_UNKNOWN;
                return 1'b1;
            end
            in_frame  = 1'b1;
            frame_len = b;
            next_pos  = 8'd1;
            type_seen = 8'd0;
            seq_seen  = 8'd0;
            code_seen = 8'd0;
            return 1'b1;
        end
        r.index = next_pos[6:0];
        case (next_pos)
            8'd1: type_seen = b;
            8'd2: seq_seen  = b;
            8'd3: code_seen = b;
            default: ;
        endcase
        if (int'(next_pos) + 1 >= int'(frame_len)) begin
            case (type_seen)
                TYPE_PONG:     r.kind = KIND_PONG;
                TYPE_HEADER:   r.kind = KIND_HEADER;
                TYPE_DATA:     r.kind = KIND_DATA;
                TYPE_HDR_ACK:  r.kind = KIND_HDR_ACK;
                TYPE_DATA_ACK: r.kind = KIND_DATA_ACK;
                default:       r.kind = KIND_UNKNOWN;
            endcase
            r.last     = 1'b1;
            r.send_ack = (r.kind == KIND_HEADER) || (r.kind == KIND_DATA);
            r.seq      = seq_seen;
            if (r.kind == KIND_HDR_ACK)
                r.ok = (seq_seen == 8'd0);
            else if (r.kind == KIND_DATA_ACK)
                r.ok = (code_seen == 8'd0);
            in_frame = 1'b0;
            next_pos = 8'd0;
        end else begin
            next_pos = next_pos + 8'd1;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame_result want;
        if (!i_rst_n) begin
            in_frame  = 1'b0;
            next_pos  = 8'd0;
            frame_len = 8'd0;
            type_seen = 8'd0;
            seq_seen  = 8'd0;
            code_seen = 8'd0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (deframe_byte(i_rx_byte, want))
                    expected_results.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, byte %0h index %0d",
                                              i_out_byte, i_byte_index));
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_byte", i_out_byte, want.data);
                    check_field("byte_index", {1'b0, i_byte_index}, {1'b0, want.index});
                    check_field("last", {7'd0, i_last}, {7'd0, want.last});
                    check_field("kind", {5'd0, i_kind}, {5'd0, want.kind});
                    check_field("send_ack", {7'd0, i_send_ack}, {7'd0, want.send_ack});
                    check_field("ack_seq", i_ack_seq, want.seq);
                    check_field("ack_ok", {7'd0, i_ack_ok}, {7'd0, want.ok});
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== test/tb_radio_serial_frame_receiver_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radio serial frame receiver testbench
// Drives directed frames and length cases, then random frame traffic mixed
// with fill bytes and bad lengths, under random stalls on both channels.
// The frame monitor predicts and checks every result; this top decides.
// ----------------------------------------------------------------------------
module tb_radio_serial_frame_receiver_unit;
    import rsfr_pkg::*;

    localparam int FRAME_LIMIT  = 100;
    localparam int TARGET_ITEMS = 740;
    localparam int CALM_ITEMS   = 620;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [7:0] DIRECTED_BYTES [26] = '{
        FILL_BYTE, 8'h00, 8'h01, 8'd100, 8'hFE,
        8'd2, TYPE_PONG,
        8'd4, TYPE_HEADER, 8'h55, 8'hAA,
        8'd4, TYPE_DATA_ACK, 8'h07, 8'h00,
        8'd3, TYPE_HDR_ACK, 8'h00,
        8'd2, TYPE_DATA_ACK,
        8'd3, TYPE_DATA, FILL_BYTE,
        8'd2, 8'h5A, 8'h7F
    };
    localparam logic [7:0] FRAME_TYPES [5] = '{
        TYPE_PONG, TYPE_HEADER, TYPE_DATA, TYPE_HDR_ACK, TYPE_DATA_ACK
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_rx_byte = 8'd0;
    logic       o_res_valid;
    logic       i_res_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic [6:0] o_byte_index;
    logic       o_last;
    t_kind      o_kind;
    logic       o_send_ack;
    logic [7:0] o_ack_seq;
    logic       o_ack_ok;

    logic calm = 1'b0;
    int   stall_left = 0;
    int   item_count = 0;
    int   fail_count;
    int   pending_count;

    radio_serial_frame_receiver_unit #(
        .FRAME_LIMIT(FRAME_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_out_byte  (o_out_byte),
        .o_byte_index(o_byte_index),
        .o_last      (o_last),
        .o_kind      (o_kind),
        .o_send_ack  (o_send_ack),
        .o_ack_seq   (o_ack_seq),
        .o_ack_ok    (o_ack_ok)
    );

    rsfr_frame_monitor #(
        .FRAME_LIMIT(FRAME_LIMIT)
    ) u_frame_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_out_byte  (o_out_byte),
        .i_byte_index(o_byte_index),
        .i_last      (o_last),
        .i_kind      (o_kind),
        .i_send_ack  (o_send_ack),
        .i_ack_seq   (o_ack_seq),
        .i_ack_ok    (o_ack_ok),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (calm) begin
            i_res_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_res_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_res_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 10);
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [7:0] seq_or_code();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return ($urandom_range(0, 2) == 0) ? 8'h00 : v;
    endfunction

    task automatic send_frame(input int len, input logic [7:0] frame_type);
        logic [7:0] v;
        v = 8'(len);
        send_byte(v);
        for (int i = 1; i < len; i++) begin
            if (i == 1) begin
                send_byte(frame_type);
            end else if (i <= 3) begin
                send_byte(seq_or_code());
            end else begin
                v = 8'($urandom_range(0, 255));
                send_byte(v);
            end
        end
        item_count += len;
    endtask

    initial begin
        int         pick;
        int         len;
        logic [7:0] v;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);
        item_count = 25;

        send_frame(FRAME_LIMIT - 1, TYPE_DATA);
        while (item_count < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_byte(FILL_BYTE);
            end else if (pick < 10) begin
                v = 8'($urandom_range(FRAME_LIMIT, 254));
                send_byte(v);
                item_count++;
            end else if (pick < 13) begin
                v = 8'($urandom_range(0, 1));
                send_byte(v);
                item_count++;
            end else begin
                if ($urandom_range(0, 24) == 0)
                    len = $urandom_range(9, FRAME_LIMIT - 1);
                else
                    len = $urandom_range(2, 8);
                if ($urandom_range(0, 4) == 0)
                    v = 8'($urandom_range(0, 255));
                else
                    v = FRAME_TYPES[$urandom_range(0, 4)];
                send_frame(len, v);
            end
            if (item_count >= CALM_ITEMS)
                calm <= 1'b1;
        end
        i_in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("radio_serial_frame_receiver_unit regression: pass");
        else
            $display("radio_serial_frame_receiver_unit regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("radio_serial_frame_receiver_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rsfr_pkg.sv
hdl/rsfr_classify.sv
hdl/radio_serial_frame_receiver_unit.sv
test/rsfr_frame_monitor.sv
test/tb_radio_serial_frame_receiver_unit.sv
